// File: rtl/htpc_pkg.sv
// Package: shared types, constants and the CORDIC angle table for the heading controller.
package htpc_pkg;

    localparam int CordicIterations = 16;
    localparam int IterW = $clog2(CordicIterations + 1);
    localparam int CordW = 46;
    localparam int ZW = 34;
    localparam logic signed [15:0] PiQ13 = 16'sd25736;
    localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
    localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam int NormShift = 40;

    localparam logic [1:0] ACT_POSE = 2'd0;
    localparam logic [1:0] ACT_TARGET = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_NOP = 2'd3;

    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_NORM,
        ST_ROT,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic is_tick;
        logic prep;
        logic norm;
        logic rot;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic rot_done;
    } dp_stat_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                5'd0: r = 34'sh3243F6A8;
                5'd1: r = 34'sh1DAC6705;
                5'd2: r = 34'sh0FADBAFC;
                5'd3: r = 34'sh07F56EA6;
                5'd4: r = 34'sh03FEAB76;
                5'd5: r = 34'sh01FFD55B;
                5'd6: r = 34'sh00FFFAAA;
                5'd7: r = 34'sh007FFF55;
                5'd8: r = 34'sh003FFFEA;
                5'd9: r = 34'sh001FFFFD;
                5'd10: r = 34'sh000FFFFF;
                5'd11: r = 34'sh0007FFFF;
                5'd12: r = 34'sh0003FFFF;
                5'd13: r = 34'sh0001FFFF;
                5'd14: r = 34'sh0000FFFF;
                5'd15: r = 34'sh00007FFF;
                5'd16: r = 34'sh00003FFF;
                5'd17: r = 34'sh00001FFF;
                5'd18: r = 34'sh00000FFF;
                5'd19: r = 34'sh000007FF;
                5'd20: r = 34'sh000003FF;
                5'd21: r = 34'sh000001FF;
                5'd22: r = 34'sh000000FF;
                5'd23: r = 34'sh0000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/htpc_if.sv
// Interfaces: input event channel and result channel.
interface htpc_in_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink (input valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  output ready);
    modport monitor (input valid, ready, action, pos_x, pos_y, quat_x, quat_y, quat_z,
                     quat_w);
endinterface

interface htpc_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] turn_command;
    logic signed [15:0] heading_error;
    logic target_coincides;
    modport source (output valid, turn_command, heading_error, target_coincides,
                    input ready);
    modport sink (input valid, turn_command, heading_error, target_coincides,
                  output ready);
    modport monitor (input valid, ready, turn_command, heading_error, target_coincides);
endinterface

// File: rtl/htpc_ctrl.sv
// Controller: sequences load, normalize, CORDIC rotations and result hand-off.
module htpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output htpc_pkg::dp_cmd_t cmd,
    input  htpc_pkg::dp_stat_t stat
);
    import htpc_pkg::*;

    state_t state_reg, state_next;
    logic tick_reg, tick_next;
    logic accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg <= tick_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tick_next = tick_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_action == ACT_POSE || in_action == ACT_TICK))
                begin
                    state_next = ST_PREP;
                    tick_next = (in_action == ACT_TICK);
                end
            end
            ST_PREP: state_next = ST_NORM;
            ST_NORM: if (stat.norm_done) state_next = ST_ROT;
            ST_ROT: if (stat.rot_done) state_next = ST_FIN;
            ST_FIN: state_next = tick_reg ? ST_OUT : ST_IDLE;
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        cmd.load = accept;
        cmd.is_tick = tick_reg;
        cmd.prep = (state_reg == ST_PREP);
        cmd.norm = (state_reg == ST_NORM);
        cmd.rot = (state_reg == ST_ROT);
        cmd.fin = (state_reg == ST_FIN);
    end

    a_out_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tick_reg) else $error("result without tick");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_fin_from_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> $past(state_reg == ST_ROT)) else $error("bad fin");
endmodule

// File: rtl/htpc_dp.sv
// Datapath: state registers, quaternion products, CORDIC atan2 and command law.
module htpc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [1:0]          in_action,
    input  logic signed [31:0]  in_pos_x,
    input  logic signed [31:0]  in_pos_y,
    input  logic signed [15:0]  in_quat_x,
    input  logic signed [15:0]  in_quat_y,
    input  logic signed [15:0]  in_quat_z,
    input  logic signed [15:0]  in_quat_w,
    input  htpc_pkg::dp_cmd_t   cmd,
    output htpc_pkg::dp_stat_t  stat,
    output logic signed [15:0]  turn_command,
    output logic signed [15:0]  heading_error,
    output logic                target_coincides
);
    import htpc_pkg::*;

    logic [15:0] gain_reg;
    logic [14:0] limit_reg, thresh_reg;
    logic signed [31:0] boat_x_reg, boat_y_reg, target_x_reg, target_y_reg;
    logic signed [15:0] heading_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [CordW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IterW-1:0] it_reg;
    logic zero_reg;
    logic signed [15:0] cmd_reg, err_reg;
    logic coin_reg;

    // quaternion products: two multipliers per axis, registered in PREP
    logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
    logic signed [CordW-1:0] num_q, den_q, dx_w, dy_w, x0, y0;
    assign p_wz = qw_reg * qz_reg;
    assign p_xy = qx_reg * qy_reg;
    assign p_yy = qy_reg * qy_reg;
    assign p_zz = qz_reg * qz_reg;
    assign num_q = CordW'(p_wz) + CordW'(p_xy) <<< 1;
    assign den_q = (CordW'(1) <<< 28) - ((CordW'(p_yy) + CordW'(p_zz)) <<< 1);
    assign dx_w = CordW'(target_x_reg) - CordW'(boat_x_reg);
    assign dy_w = CordW'(target_y_reg) - CordW'(boat_y_reg);
    assign x0 = cmd.is_tick ? dx_w : den_q;
    assign y0 = cmd.is_tick ? dy_w : num_q;

    logic signed [CordW-1:0] ax, ay, xs, ys;
    logic [4:0] it5;
    assign ax = x_reg[CordW-1] ? -x_reg : x_reg;
    assign ay = y_reg[CordW-1] ? -y_reg : y_reg;
    assign it5 = 5'(it_reg);
    assign xs = x_reg >>> it5;
    assign ys = y_reg >>> it5;
    // a zero vector needs no shifts
    assign stat.norm_done = zero_reg ||
                            (ax >= (CordW'(1) <<< NormShift)) ||
                            (ay >= (CordW'(1) <<< NormShift));
    assign stat.rot_done = (it_reg == IterW'(CordicIterations - 1));

    // final angle, wrap and command law
    logic signed [ZW-1:0] zr;
    logic signed [15:0] ang;
    logic signed [16:0] diff, wrapped;
    logic signed [32:0] prod;
    logic signed [25:0] pcmd;
    logic signed [15:0] lim_s, cmd_v;
    assign zr = (z_reg + ZW'(65536)) >>> 17;
    assign ang = zero_reg ? 16'sd0 :
                 (zr > ZW'(PiQ13)) ? PiQ13 :
                 (zr < -ZW'(PiQ13)) ? -PiQ13 : zr[15:0];
    assign diff = 17'(ang) - 17'(heading_reg);
    assign wrapped = (diff > 17'(PiQ13)) ? diff - TwoPiQ13 :
                     (diff <= -17'(PiQ13)) ? diff + TwoPiQ13 : diff;
    assign prod = $signed({1'b0, gain_reg}) * wrapped;
    assign pcmd = 26'((prod + 33'sd64) >>> 7);
    assign lim_s = 16'({1'b0, limit_reg});
    always_comb
    begin
        if (zero_reg || wrapped > 17'($signed({1'b0, thresh_reg})))
            cmd_v = -lim_s;
        else if (pcmd > 26'(lim_s))
            cmd_v = lim_s;
        else if (pcmd < -26'(lim_s))
            cmd_v = -lim_s;
        else
            cmd_v = pcmd[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 16'd256;
            limit_reg <= 15'd9830;
            thresh_reg <= 15'd6434;
            boat_x_reg <= '0;
            boat_y_reg <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GAIN) gain_reg <= cfg_data;
                else if (cfg_index == REG_LIMIT) limit_reg <= cfg_data[14:0];
                else if (cfg_index == REG_THRESH) thresh_reg <= cfg_data[14:0];
            end
            if (cmd.load && in_action == ACT_POSE)
            begin
                boat_x_reg <= in_pos_x;
                boat_y_reg <= in_pos_y;
            end
            if (cmd.load && in_action == ACT_TARGET)
            begin
                target_x_reg <= in_pos_x;
                target_y_reg <= in_pos_y;
            end
            if (cmd.fin && !cmd.is_tick)
                heading_reg <= ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qx_reg <= in_quat_x;
            qy_reg <= in_quat_y;
            qz_reg <= in_quat_z;
            qw_reg <= in_quat_w;
        end
        if (cmd.prep)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= '0;
            it_reg <= '0;
            zero_reg <= (x0 == '0) && (y0 == '0);
        end
        if (cmd.norm)
        begin
            // when normalized or zero: a vector with x<0 is turned by 90 degrees
            if (stat.norm_done || zero_reg)
            begin
                if (x_reg[CordW-1])
                begin
                    if (!y_reg[CordW-1])
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= HalfPiQ30;
                    end
                    else
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= -HalfPiQ30;
                    end
                end
            end
            else
            begin
                x_reg <= x_reg <<< 1;
                y_reg <= y_reg <<< 1;
            end
        end
        if (cmd.rot)
        begin
            if (!y_reg[CordW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_q30(it5);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_q30(it5);
            end
            it_reg <= it_reg + IterW'(1);
        end
        if (cmd.fin)
        begin
            cmd_reg <= cmd_v;
            err_reg <= zero_reg ? 16'sd0 : wrapped[15:0];
            coin_reg <= zero_reg;
        end
    end

    assign turn_command = cmd_reg;
    assign heading_error = err_reg;
    assign target_coincides = coin_reg;

    a_hold_heading: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.fin) |-> $stable(heading_reg)) else $error("heading moved");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot |-> it_reg < IterW'(CordicIterations)) else $error("iter overrun");
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.fin) |-> (cmd_reg <= lim_s && cmd_reg >= -lim_s)) else $error("sat");
endmodule

// File: rtl/heading_to_target_p_controller_core.sv
// Top level: proportional heading-to-target controller.
// Pose and tick events pass PREP, NORM (left shifts until |x| or |y| reaches 2^40),
// ROT and FIN; input is ready again after FIN for a pose, while a tick holds in OUT
// until the result transfer. One event is taken at a time; target events and action
// three are taken in idle and give no result. Reset (rst_n, async low) sets control
// state, positions and heading to zero and config registers to defaults.
module heading_to_target_p_controller_core (
    input  logic clk,
    input  logic rst_n,
    htpc_in_if.sink    in_ch,
    htpc_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import htpc_pkg::*;

    dp_cmd_t cmd;
    dp_stat_t stat;

    // sequence the event through the shared CORDIC
    htpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_action(in_ch.action), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat)
    );

    // hold state and compute angles and command
    htpc_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_action(in_ch.action), .in_pos_x(in_ch.pos_x), .in_pos_y(in_ch.pos_y),
        .in_quat_x(in_ch.quat_x), .in_quat_y(in_ch.quat_y),
        .in_quat_z(in_ch.quat_z), .in_quat_w(in_ch.quat_w),
        .cmd(cmd), .stat(stat),
        .turn_command(out_ch.turn_command), .heading_error(out_ch.heading_error),
        .target_coincides(out_ch.target_coincides)
    );
endmodule
